### rtl/core/mrrc_pkg.sv
// Shared types, codes and defaults for the ring cursor manager.
// Used by the channel interfaces, the divider, the top level and the checker.
package mrrc_pkg;

  localparam int BUF_MULT_DEF    = 2;
  localparam int MAX_READERS_DEF = 16;
  localparam int FRAME_BITS_DEF  = 48;

  localparam int MODE_W   = 3;
  localparam int ID_W     = 4;
  localparam int FC_W     = 16;
  localparam int CS_W     = 48;
  localparam int POS_W    = 15;
  localparam int AVAIL_W  = 16;
  localparam int CYC_W    = 16;
  localparam int STATUS_W = 2;
  localparam int BLK_W    = 13;
  localparam int RING_W   = 16;

  localparam logic [BLK_W-1:0] BLK_RESET = 13'd512;
  localparam logic [BLK_W-1:0] BLK_MAX   = 13'd4096;
  localparam logic [BLK_W-1:0] BLK_MIN   = 13'd1;

  typedef enum logic [MODE_W-1:0] {
    MODE_RESET   = 3'd0,
    MODE_ADD     = 3'd1,
    MODE_REMOVE  = 3'd2,
    MODE_ADVANCE = 3'd3,
    MODE_PREP    = 3'd4,
    MODE_ROOM    = 3'd5,
    MODE_AVAIL   = 3'd6,
    MODE_PULL    = 3'd7
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_UNKNOWN = 2'd1,
    ST_FULL    = 2'd2,
    ST_TOOBIG  = 2'd3
  } status_t;

  typedef struct packed {
    logic done;
    logic busy;
  } div_stat_t;

endpackage

### rtl/core/mrrc_if.sv
// Request, response and block-size write channels of the ring cursor manager.
// Depends on mrrc_pkg for field widths.
interface mrrc_req_if;
  logic                             valid;
  logic                             ready;
  logic [mrrc_pkg::MODE_W-1:0]      mode;
  logic [mrrc_pkg::ID_W-1:0]        consumer_id;
  logic [mrrc_pkg::FC_W-1:0]        frame_count;
  logic [mrrc_pkg::CS_W-1:0]        cycle_start;
  logic [mrrc_pkg::CS_W-1:0]        global_start;
  modport source (output valid, mode, consumer_id, frame_count, cycle_start, global_start,
                  input ready);
  modport sink (input valid, mode, consumer_id, frame_count, cycle_start, global_start,
                output ready);
endinterface

interface mrrc_rsp_if;
  logic                             valid;
  logic                             ready;
  logic [mrrc_pkg::POS_W-1:0]       position;
  logic [mrrc_pkg::AVAIL_W-1:0]     available;
  logic                             room_ok;
  logic [mrrc_pkg::CYC_W-1:0]       writer_cycles;
  logic [mrrc_pkg::STATUS_W-1:0]    status;
  modport source (output valid, position, available, room_ok, writer_cycles, status,
                  input ready);
  modport sink (input valid, position, available, room_ok, writer_cycles, status,
                output ready);
endinterface

interface mrrc_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [mrrc_pkg::BLK_W-1:0]       data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

### rtl/core/multi_reader_ring_cursor_manager_unit.sv
// Ring cursor manager top level: sequencer, cursor registers and the shared divider.
// Depends on mrrc_pkg, mrrc_if and mrrc_div.
//
//   channel  dir  carries
//   req      in   mode, consumer_id, frame_count, cycle_start, global_start
//   rsp      out  position, available, room_ok, writer_cycles, status
//   cfg      in   block_frames (always ready)
//
// Reset, add, remove and advance finish in S_EXEC; available adds the backlog step S_BL.
// Room check: two steps per reader on the backlog subtractor, skipped when the block was already written this cycle.
// Prepare write runs the divider, plus the fix-up step S_PREP_FIX when the block was already written this cycle;
// pull runs the bit-serial divider up to twice.
// rst is synchronous; it clears cursors' valid bits, counters and block size (512).
// req is not ready while a request is in flight; a stalled rsp holds the finished request.
module multi_reader_ring_cursor_manager_unit #(
  parameter int BUFFER_MULTIPLIER = mrrc_pkg::BUF_MULT_DEF,
  parameter int MAX_READERS       = mrrc_pkg::MAX_READERS_DEF,
  parameter int FRAME_BITS        = mrrc_pkg::FRAME_BITS_DEF
) (
  input logic        clk,
  input logic        rst,
  mrrc_req_if.sink   req,
  mrrc_rsp_if.source rsp,
  mrrc_cfg_if.sink   cfg
);
  localparam int RW  = (MAX_READERS > 1) ? $clog2(MAX_READERS) : 1;
  localparam int SW  = mrrc_pkg::RING_W;
  localparam int BW  = mrrc_pkg::BLK_W;
  localparam int FCW = mrrc_pkg::FC_W;

  typedef enum logic [14:0] {
    S_IDLE      = 15'b000000000000001,
    S_EXEC      = 15'b000000000000010,
    S_BL        = 15'b000000000000100,
    S_ROOM_A    = 15'b000000000001000,
    S_ROOM_B    = 15'b000000000010000,
    S_PREP_WAIT = 15'b000000000100000,
    S_PREP_FIX  = 15'b000000001000000,
    S_PULL_FF   = 15'b000000010000000,
    S_PULL_CMP  = 15'b000000100000000,
    S_PULL_DIV  = 15'b000001000000000,
    S_PULL_MUL  = 15'b000010000000000,
    S_PULL_ADD  = 15'b000100000000000,
    S_PULL_POS  = 15'b001000000000000,
    S_PULL_POSW = 15'b010000000000000,
    S_DONE      = 15'b100000000000000
  } state_t;

  state_t state;

  logic [BW-1:0]            block_frames;
  logic [FRAME_BITS-1:0]    produced;
  logic [mrrc_pkg::CS_W-1:0] last_cs;
  logic                     last_valid;
  logic [FRAME_BITS-1:0]    cc [MAX_READERS];
  logic [MAX_READERS-1:0]   rvalid;

  logic [mrrc_pkg::MODE_W-1:0] mode_q;
  logic [mrrc_pkg::ID_W-1:0]   id_q;
  logic [FCW-1:0]              fc_q;
  logic [mrrc_pkg::CS_W-1:0]   cs_q;
  logic [mrrc_pkg::CS_W-1:0]   gs_q;

  logic [RW-1:0]   ri;
  logic [SW-1:0]   bl_q;
  logic [FCW-1:0]  cyc_q;
  logic [28:0]     inc_q;

  logic [mrrc_pkg::POS_W-1:0]    res_pos;
  logic [mrrc_pkg::AVAIL_W-1:0]  res_avail;
  logic                          res_room;
  logic [mrrc_pkg::CYC_W-1:0]    res_cyc;
  logic [mrrc_pkg::STATUS_W-1:0] res_status;

  logic [BW-1:0]          blk;
  logic [SW-1:0]          ring_s;
  logic [RW-1:0]          r;
  logic                   id_ok;
  logic                   known;
  logic                   same;
  logic [RW-1:0]          sel;
  logic [FRAME_BITS-1:0]  diff;
  logic [SW-1:0]          clamp;
  logic [FRAME_BITS-1:0]  gfloor;
  logic [FRAME_BITS-1:0]  start_val;
  logic [SW:0]            fix_sum;
  logic [SW:0]            room_sum;

  logic                   div_start;
  logic [FRAME_BITS-1:0]  div_dividend;
  logic [SW-1:0]          div_divisor;
  logic [FRAME_BITS-1:0]  div_quo;
  logic [SW-1:0]          div_rem;
  mrrc_pkg::div_stat_t    dstat;
  logic                   accept;

  mrrc_div #(.FRAME_BITS(FRAME_BITS)) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .quotient  (div_quo),
    .remainder (div_rem),
    .stat      (dstat)
  );

  always_comb begin
    if (block_frames < mrrc_pkg::BLK_MIN) begin
      blk = mrrc_pkg::BLK_MIN;
    end else if (block_frames > mrrc_pkg::BLK_MAX) begin
      blk = mrrc_pkg::BLK_MAX;
    end else begin
      blk = block_frames;
    end
    ring_s = SW'(SW'(blk) * SW'(BUFFER_MULTIPLIER));
    r      = RW'(id_q);
    id_ok  = 32'(id_q) < MAX_READERS;
    known  = id_ok && rvalid[r];
    same   = last_valid && (last_cs == cs_q);
    sel    = (state == S_ROOM_A) ? ri : r;
    // backlog is read as signed; negative counts as empty
    diff   = produced - cc[sel];
    if (diff[FRAME_BITS-1]) begin
      clamp = '0;
    end else if (diff > FRAME_BITS'(ring_s)) begin
      clamp = ring_s;
    end else begin
      clamp = diff[SW-1:0];
    end
    gfloor    = FRAME_BITS'(gs_q);
    start_val = (gfloor > produced) ? gfloor : produced;
    fix_sum   = {1'b0, div_rem} + {1'b0, ring_s} - (SW + 1)'(blk);
    room_sum  = {1'b0, bl_q} + (SW + 1)'(blk);
  end

  always_comb begin
    div_start    = 1'b0;
    div_dividend = produced;
    div_divisor  = ring_s;
    case (state)
      S_EXEC: begin
        div_start = (mrrc_pkg::mode_t'(mode_q) == mrrc_pkg::MODE_PREP);
      end
      S_PULL_CMP: begin
        div_start    = (bl_q < fc_q);
        div_dividend = FRAME_BITS'(17'(fc_q) - 17'(bl_q) + 17'(blk) - 17'd1);
        div_divisor  = SW'(blk);
      end
      S_PULL_POS: begin
        div_start    = 1'b1;
        div_dividend = cc[r];
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  assign accept    = req.valid && req.ready;
  assign req.ready = (state == S_IDLE) && !dstat.busy;
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      block_frames <= mrrc_pkg::BLK_RESET;
      produced     <= '0;
      last_cs      <= '0;
      last_valid   <= 1'b0;
      rvalid       <= '0;
      rsp.valid    <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        block_frames <= cfg.data;
      end
      // drop a taken response unless a new one replaces it below
      if (rsp.valid && rsp.ready && state != S_DONE) begin
        rsp.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            mode_q     <= req.mode;
            id_q       <= req.consumer_id;
            fc_q       <= req.frame_count;
            cs_q       <= req.cycle_start;
            gs_q       <= req.global_start;
            res_pos    <= '0;
            res_avail  <= '0;
            res_room   <= 1'b0;
            res_cyc    <= '0;
            res_status <= mrrc_pkg::ST_OK;
            state      <= S_EXEC;
          end
        end
        S_EXEC: begin
          state <= S_DONE;
          case (mrrc_pkg::mode_t'(mode_q))
            mrrc_pkg::MODE_RESET: begin
              produced <= '0;
            end
            mrrc_pkg::MODE_ADD: begin
              if (!id_ok) begin
                res_status <= mrrc_pkg::ST_FULL;
              end else begin
                rvalid[r] <= 1'b1;
              end
            end
            mrrc_pkg::MODE_REMOVE: begin
              if (!known) begin
                res_status <= mrrc_pkg::ST_UNKNOWN;
              end else begin
                rvalid[r] <= 1'b0;
              end
            end
            mrrc_pkg::MODE_ADVANCE: begin
              if (!same) begin
                produced   <= produced + FRAME_BITS'(fc_q);
                last_cs    <= cs_q;
                last_valid <= 1'b1;
              end
            end
            mrrc_pkg::MODE_PREP: begin
              state <= S_PREP_WAIT;
            end
            mrrc_pkg::MODE_ROOM: begin
              res_room <= 1'b1;
              ri       <= '0;
              if (!same) begin
                state <= S_ROOM_A;
              end
            end
            mrrc_pkg::MODE_AVAIL: begin
              if (!known) begin
                res_status <= mrrc_pkg::ST_UNKNOWN;
              end else begin
                state <= S_BL;
              end
            end
            mrrc_pkg::MODE_PULL: begin
              if (!known) begin
                res_status <= mrrc_pkg::ST_UNKNOWN;
              end else if (fc_q > ring_s) begin
                res_status <= mrrc_pkg::ST_TOOBIG;
              end else begin
                state <= S_PULL_FF;
              end
            end
            default: begin
              state <= S_DONE;
            end
          endcase
        end
        S_BL: begin
          bl_q <= clamp;
          if (mrrc_pkg::mode_t'(mode_q) == mrrc_pkg::MODE_PULL) begin
            state <= S_PULL_CMP;
          end else begin
            res_avail <= clamp;
            state     <= S_DONE;
          end
        end
        S_ROOM_A: begin
          bl_q  <= clamp;
          state <= S_ROOM_B;
        end
        S_ROOM_B: begin
          if (rvalid[ri] && (room_sum > (SW + 1)'(ring_s))) begin
            res_room <= 1'b0;
          end
          ri <= ri + RW'(1);
          if (32'(ri) == MAX_READERS - 1) begin
            state <= S_DONE;
          end else begin
            state <= S_ROOM_A;
          end
        end
        S_PREP_WAIT: begin
          if (dstat.done) begin
            state <= same ? S_PREP_FIX : S_DONE;
            res_pos <= div_rem[mrrc_pkg::POS_W-1:0];
          end
        end
        S_PREP_FIX: begin
          // start of the block written last, wrapped into the ring
          if (fix_sum >= (SW + 1)'(ring_s)) begin
            res_pos <= mrrc_pkg::POS_W'(fix_sum - (SW + 1)'(ring_s));
          end else begin
            res_pos <= mrrc_pkg::POS_W'(fix_sum);
          end
          state <= S_DONE;
        end
        S_PULL_FF: begin
          // fast-forward a producer that lags this reader
          if (diff[FRAME_BITS-1]) begin
            produced <= cc[r];
          end
          state <= S_BL;
        end
        S_PULL_CMP: begin
          cyc_q <= '0;
          state <= (bl_q < fc_q) ? S_PULL_DIV : S_PULL_POS;
        end
        S_PULL_DIV: begin
          if (dstat.done) begin
            cyc_q   <= div_quo[FCW-1:0];
            res_cyc <= div_quo[FCW-1:0];
            state   <= S_PULL_MUL;
          end
        end
        S_PULL_MUL: begin
          inc_q <= 29'(cyc_q) * 29'(blk);
          state <= S_PULL_ADD;
        end
        S_PULL_ADD: begin
          produced <= produced + FRAME_BITS'(inc_q);
          state    <= S_PULL_POS;
        end
        S_PULL_POS: begin
          state <= S_PULL_POSW;
        end
        S_PULL_POSW: begin
          if (dstat.done) begin
            res_pos <= div_rem[mrrc_pkg::POS_W-1:0];
            state   <= S_DONE;
          end
        end
        S_DONE: begin
          // hold until the output register is free
          if (!rsp.valid || rsp.ready) begin
            rsp.valid         <= 1'b1;
            rsp.position      <= res_pos;
            rsp.available     <= res_avail;
            rsp.room_ok       <= res_room;
            rsp.writer_cycles <= res_cyc;
            rsp.status        <= res_status;
            state             <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // cursor store, no reset: an entry is written when its reader is added
  always_ff @(posedge clk) begin
    if (state == S_EXEC && mrrc_pkg::mode_t'(mode_q) == mrrc_pkg::MODE_RESET) begin
      for (int i = 0; i < MAX_READERS; i++) begin
        if (rvalid[i]) begin
          cc[i] <= '0;
        end
      end
    end else if (state == S_EXEC && mrrc_pkg::mode_t'(mode_q) == mrrc_pkg::MODE_ADD && id_ok) begin
      cc[r] <= start_val;
    end else if (state == S_PULL_POSW && dstat.done) begin
      cc[r] <= cc[r] + FRAME_BITS'(fc_q);
    end
  end

endmodule

### rtl/core/mrrc_div.sv
// Shared restoring divider: one quotient bit per cycle, FRAME_BITS quotient bits per division.
// Depends on mrrc_pkg for the status struct and ring width.
module mrrc_div #(
  parameter int FRAME_BITS = mrrc_pkg::FRAME_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [FRAME_BITS-1:0]         dividend,
  input  logic [mrrc_pkg::RING_W-1:0]   divisor,
  output logic [FRAME_BITS-1:0]         quotient,
  output logic [mrrc_pkg::RING_W-1:0]   remainder,
  output mrrc_pkg::div_stat_t           stat
);
  localparam int CW = $clog2(FRAME_BITS + 1);
  localparam int RW = mrrc_pkg::RING_W;

  logic [FRAME_BITS-1:0] dq;
  logic [RW-1:0]         rem;
  logic [RW-1:0]         dv;
  logic [CW-1:0]         cnt;
  logic                  busy;
  logic                  done;
  logic [RW:0]           trial;
  logic                  ge;
  logic [RW-1:0]         rem_next;

  always_comb begin
    trial    = {rem, dq[FRAME_BITS-1]};
    ge       = trial >= {1'b0, dv};
    rem_next = ge ? RW'(trial - {1'b0, dv}) : trial[RW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        dq   <= dividend;
        rem  <= '0;
        dv   <= divisor;
        cnt  <= CW'(FRAME_BITS);
        busy <= 1'b1;
      end else if (busy) begin
        rem <= rem_next;
        dq  <= {dq[FRAME_BITS-2:0], ge};
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient  = dq;
  assign remainder = rem;
  assign stat.done = done;
  assign stat.busy = busy;

endmodule

### rtl/core/mrrc_checker.sv
// Port-level checks for the ring cursor manager, bound to the top level.
// Depends on mrrc_pkg for status codes.
module mrrc_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            req_valid,
  input logic                            req_ready,
  input logic                            rsp_valid,
  input logic                            rsp_ready,
  input logic                            rsp_room_ok,
  input logic [mrrc_pkg::STATUS_W-1:0]   rsp_status,
  input logic [mrrc_pkg::CYC_W-1:0]      rsp_writer_cycles
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("response dropped while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request accepted while previous one in flight");

  a_rsp_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(!req_ready))
    else $error("response appeared without a request in flight");

  a_room_clean: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_room_ok |-> rsp_status == mrrc_pkg::ST_OK && rsp_writer_cycles == '0)
    else $error("room check result carries foreign fields");

endmodule

bind multi_reader_ring_cursor_manager_unit mrrc_checker u_mrrc_checker (
  .clk               (clk),
  .rst               (rst),
  .req_valid         (req.valid),
  .req_ready         (req.ready),
  .rsp_valid         (rsp.valid),
  .rsp_ready         (rsp.ready),
  .rsp_room_ok       (rsp.room_ok),
  .rsp_status        (rsp.status),
  .rsp_writer_cycles (rsp.writer_cycles)
);
